>>> rtl/core/afl_pkg.sv
// Shared types and constants for the sprite animation timeline store.
// Used by the timeline cell, the modulo unit and the top level.
package afl_pkg;

    // field widths fixed by the item format
    localparam int TOTAL_W = 24;
    localparam int LEN_W   = 16;
    localparam int REF_W   = 16;
    localparam int TAG_W   = 9;
    localparam int QT_W    = 32;
    localparam int IDX_W   = 7;
    localparam int CMD_W   = 3;
    localparam int MODE_W  = 2;

    // modulo unit: one quotient bit per cycle over the non-negative time bits
    localparam int DIV_STEPS = QT_W - 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_END    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    // loop modes
    localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

    // saturation value of the running total
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // one timeline entry as held in a cell
    typedef struct packed {
        logic [TOTAL_W-1:0]      start;
        logic [LEN_W-1:0]        length;
        logic [REF_W-1:0]        frame_ref;
        logic signed [TAG_W-1:0] tag;
    } t_entry;

endpackage

>>> rtl/core/afl_cell.sv
// One storage cell of the circulating timeline ring.
// Depends on afl_pkg for the entry type.
module afl_cell
    import afl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_entry i_d,
    output t_entry o_q
);

    t_entry r_q;

    // take the neighbour's entry on every shift cycle
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

>>> rtl/core/afl_mod_unit.sv
// Bit-serial restoring modulo unit: non-negative time modulo the total.
// Depends on afl_pkg for widths.
module afl_mod_unit
    import afl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [QT_W-2:0]    i_dividend,
    input  logic [TOTAL_W-1:0] i_divisor,
    output logic               o_done,
    output logic [TOTAL_W-1:0] o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [QT_W-2:0]      r_dvd;
    logic [TOTAL_W-1:0]   r_div;
    logic [TOTAL_W-1:0]   r_rem;
    logic [TOTAL_W:0]     trial;
    logic [TOTAL_W-1:0]   n_rem;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[QT_W-2]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = TOTAL_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[TOTAL_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[QT_W-3:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/animation_frame_timeline_lookup.sv
// Sprite animation timeline store: a ring of MAX_ENTRIES cells that circulates once per
// sweep. Depends on afl_pkg, afl_cell and afl_mod_unit.
//
// Timing for the user: one command at a time; busy is high from acceptance until the
// result strobe, and the result appears for one cycle with o_strobe (no back-pressure).
// Clear, unknown codes, a rejected append, a closing end, a read out of range and a
// query that misses up front go straight to the done state. An accepted append and an
// in-range read turn the entry ring once, and the head cell is examined each cycle. A
// query first runs the bit-serial modulo unit (31 steps and the hand-over), then makes
// one ring turn for the linear search. An end in ping-pong mode with n >= 3 entries
// makes one ring turn per mirrored entry (entries n - 2 down to 1).
module animation_frame_timeline_lookup
    import afl_pkg::*;
#(
    parameter int MAX_ENTRIES = 128
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic [MODE_W-1:0]         i_cfg_wdata,
    input  logic [CMD_W-1:0]          i_cmd,
    input  logic                      i_sprite_valid,
    input  logic signed [TAG_W-1:0]   i_tag_code,
    input  logic [REF_W-1:0]          i_frame_ref,
    input  logic [LEN_W-1:0]          i_frame_length,
    input  logic signed [QT_W-1:0]    i_query_time,
    input  logic [IDX_W-1:0]          i_entry_index,
    output logic                      o_strobe,
    output logic                      o_ok_flag,
    output logic                      o_hit,
    output logic [IDX_W-1:0]          o_found_index,
    output logic [REF_W-1:0]          o_out_ref,
    output logic signed [TAG_W-1:0]   o_out_tag,
    output logic [TOTAL_W-1:0]        o_out_start,
    output logic [LEN_W-1:0]          o_out_length,
    output logic [TOTAL_W-1:0]        o_out_total
);

    localparam int SW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int HALF = MAX_ENTRIES / 2;
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state             r_state;
    logic [MODE_W-1:0]  r_loop_mode;
    logic [CW-1:0]      r_count;
    logic [TOTAL_W-1:0] r_total;
    logic               r_appending;
    logic [CMD_W-1:0]   r_cmd;
    logic               r_ok;
    logic               r_hit;
    logic [IDX_W-1:0]   r_fidx;
    t_entry             r_fent;
    t_entry             r_new;
    t_entry             r_hold;
    logic [CW-1:0]      r_k;
    logic [SW-1:0]      r_step;
    logic [TOTAL_W-1:0] r_tm;
    logic [IDX_W-1:0]   r_idx;

    t_entry             cell_q [MAX_ENTRIES];
    t_entry             head;
    t_entry             wr_src;
    t_entry             tail_in;
    logic               accept;
    logic               shift;
    logic [CW-1:0]      step_c;
    logic               wr_now;
    logic               last_step;
    logic               in_range;
    logic               covered;
    logic [TOTAL_W:0]   head_end;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] n_total;
    logic               app_ok;
    logic               mirror_go;
    logic               query_go;
    logic               read_go;
    logic               div_start;
    logic               div_done;
    logic [TOTAL_W-1:0] div_rem;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign shift  = (r_state == ST_SWEEP);

    // up-front decisions on the incoming item
    assign app_ok    = r_appending && i_sprite_valid && (r_count < CW'(HALF));
    assign mirror_go = r_appending && (r_loop_mode == MODE_PINGPONG) && (r_count >= CW'(3));
    assign query_go  = !i_query_time[QT_W-1]
                       && !((r_loop_mode == MODE_ONCE) && (i_query_time >= QT_W'(r_total)))
                       && (r_total != '0);
    assign read_go   = CMPW'(i_entry_index) < CMPW'(r_count);
    assign div_start = accept && (i_cmd == CMD_QUERY) && query_go;

    afl_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_query_time[QT_W-2:0]),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // ring of cells: every cell hands its entry down, the head feeds the tail
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        if (g == MAX_ENTRIES - 1) begin : g_tail
            afl_cell u_cell (.i_clk(i_clk), .i_shift(shift), .i_d(tail_in), .o_q(cell_q[g]));
        end else begin : g_body
            afl_cell u_cell (.i_clk(i_clk), .i_shift(shift), .i_d(cell_q[g+1]), .o_q(cell_q[g]));
        end
    end

    // head cell holds entry r_step during the sweep
    always_comb begin
        head      = cell_q[0];
        step_c    = CW'(r_step);
        last_step = (r_step == SW'(MAX_ENTRIES - 1));
        in_range  = step_c < r_count;
        // append writes the new entry, mirror writes the held copy, at slot r_count
        wr_src    = (r_cmd == CMD_APPEND) ? r_new : r_hold;
        wr_now    = shift && (step_c == r_count)
                    && ((r_cmd == CMD_APPEND) || (r_cmd == CMD_END));
        tail_in   = head;
        if (wr_now) begin
            tail_in.start     = r_total;
            tail_in.length    = wr_src.length;
            tail_in.frame_ref = wr_src.frame_ref;
            tail_in.tag       = wr_src.tag;
        end
        // running total saturates
        sum     = {1'b0, r_total} + (TOTAL_W + 1)'(wr_src.length);
        n_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        // does the head entry cover the reduced time
        head_end = {1'b0, head.start} + (TOTAL_W + 1)'(head.length);
        covered  = (r_tm >= head.start) && ({1'b0, r_tm} < head_end);
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_mode <= MODE_ONCE;
        end else if (i_cfg_we) begin
            r_loop_mode <= i_cfg_wdata;
        end
    end

    // command sequencer and timeline state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_appending <= 1'b0;
            r_step      <= '0;
            o_strobe    <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_step <= '0;
                        unique case (i_cmd)
                            CMD_CLEAR: begin
                                r_count     <= '0;
                                r_total     <= '0;
                                r_appending <= 1'b1;
                                r_state     <= ST_DONE;
                            end
                            CMD_APPEND: begin
                                r_state <= app_ok ? ST_SWEEP : ST_DONE;
                            end
                            CMD_END: begin
                                r_appending <= 1'b0;
                                r_state     <= mirror_go ? ST_SWEEP : ST_DONE;
                            end
                            CMD_QUERY: begin
                                r_state <= query_go ? ST_DIV : ST_DONE;
                            end
                            CMD_READ: begin
                                r_state <= read_go ? ST_SWEEP : ST_DONE;
                            end
                            default: begin
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (wr_now) begin
                        r_total <= n_total;
                    end
                    if (last_step) begin
                        r_step <= '0;
                        // one slot written per turn; it counts once the turn is over
                        if ((r_cmd == CMD_APPEND) || (r_cmd == CMD_END)) begin
                            r_count <= r_count + 1'b1;
                        end
                        // mirror never overruns: the count is at most half before it
                        if ((r_cmd == CMD_END) && (r_k != CW'(1))) begin
                            r_state <= ST_SWEEP;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_DONE: begin
                    o_strobe <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // item payload, search capture and result registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd           <= i_cmd;
            r_ok            <= !((i_cmd == CMD_APPEND) && !app_ok);
            r_hit           <= 1'b0;
            r_new.start     <= '0;
            r_new.length    <= i_frame_length;
            r_new.frame_ref <= i_frame_ref;
            r_new.tag       <= i_tag_code;
            r_idx           <= i_entry_index;
            r_k             <= r_count - CW'(2);
        end
        if (div_done) begin
            r_tm <= div_rem;
        end
        if (shift) begin
            if ((r_cmd == CMD_END) && (step_c == r_k)) begin
                r_hold <= head;
            end
            if ((r_cmd == CMD_END) && last_step) begin
                r_k <= r_k - 1'b1;
            end
            if ((r_cmd == CMD_QUERY) && !r_hit && in_range && covered) begin
                r_hit  <= 1'b1;
                r_fidx <= IDX_W'(r_step);
                r_fent <= head;
            end
            if ((r_cmd == CMD_READ) && (CMPW'(r_step) == CMPW'(r_idx))) begin
                r_hit  <= 1'b1;
                r_fidx <= IDX_W'(r_step);
                r_fent <= head;
            end
        end
        if (r_state == ST_DONE) begin
            o_ok_flag     <= r_ok;
            o_hit         <= r_hit;
            o_found_index <= r_hit ? r_fidx : '0;
            o_out_ref     <= r_hit ? r_fent.frame_ref : '0;
            o_out_tag     <= r_hit ? r_fent.tag : '0;
            o_out_start   <= r_hit ? r_fent.start : '0;
            o_out_length  <= r_hit ? r_fent.length : '0;
            o_out_total   <= r_total;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count beyond capacity");

    a_open_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_appending |-> (r_count <= CW'(HALF)))
        else $error("open timeline holds more than half the capacity");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_hit) |-> ((o_found_index == '0) && (o_out_start == '0)
                                  && (o_out_length == '0)))
        else $error("miss result carries entry fields");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && !o_strobe))
        else $error("accepted item did not raise busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while still working");

endmodule

>>> sim/animation_frame_timeline_lookup_checker.sv
// Checker for the sprite animation timeline store: follows accepted commands and loop
// mode writes, predicts each result and compares it with the strobed one.
// Depends on afl_pkg.
module animation_frame_timeline_lookup_checker
    import afl_pkg::*;
#(
    parameter int MAX_ENTRIES = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    i_cfg_we,
    input  logic [MODE_W-1:0]       i_cfg_wdata,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic                    i_sprite_valid,
    input  logic signed [TAG_W-1:0] i_tag_code,
    input  logic [REF_W-1:0]        i_frame_ref,
    input  logic [LEN_W-1:0]        i_frame_length,
    input  logic signed [QT_W-1:0]  i_query_time,
    input  logic [IDX_W-1:0]        i_entry_index,
    input  logic                    o_strobe,
    input  logic                    o_ok_flag,
    input  logic                    o_hit,
    input  logic [IDX_W-1:0]        o_found_index,
    input  logic [REF_W-1:0]        o_out_ref,
    input  logic signed [TAG_W-1:0] o_out_tag,
    input  logic [TOTAL_W-1:0]      o_out_start,
    input  logic [LEN_W-1:0]        o_out_length,
    input  logic [TOTAL_W-1:0]      o_out_total,
    output int                      o_fail_count,
    output int                      o_results_owed
);

    // one predicted result item
    typedef struct packed {
        logic                    ok;
        logic                    hit;
        logic [IDX_W-1:0]        index;
        logic [REF_W-1:0]        frame_ref;
        logic signed [TAG_W-1:0] tag;
        logic [TOTAL_W-1:0]      start_time;
        logic [LEN_W-1:0]        length;
        logic [TOTAL_W-1:0]      total;
    } t_lookup_reply;

    // shadow copy of the timeline
    t_entry             timeline [MAX_ENTRIES];
    int unsigned        n_entries;
    logic [TOTAL_W-1:0] run_total;
    logic               appending;
    logic [MODE_W-1:0]  play_mode;

    t_lookup_reply      replies_due [$];
    int                 mismatches = 0;

    // add a frame at the running total, which saturates
    task automatic place_entry(input logic [LEN_W-1:0] len, input logic [REF_W-1:0] fref,
                               input logic signed [TAG_W-1:0] tag);
        logic [TOTAL_W:0] sum;
        timeline[n_entries] = '{start: run_total, length: len, frame_ref: fref, tag: tag};
        n_entries++;
        sum = run_total + len;
        run_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    endtask

    function automatic t_lookup_reply entry_reply(input int unsigned i);
        t_lookup_reply r;
        r = '0;
        r.ok         = 1'b1;
        r.hit        = 1'b1;
        r.index      = IDX_W'(i);
        r.frame_ref  = timeline[i].frame_ref;
        r.tag        = timeline[i].tag;
        r.start_time = timeline[i].start;
        r.length     = timeline[i].length;
        return r;
    endfunction

    // apply one command to the shadow timeline and work out its result
    task automatic predict_lookup(input logic [CMD_W-1:0] cmd, input logic sprite_valid,
                                  input logic signed [TAG_W-1:0] tag,
                                  input logic [REF_W-1:0] fref,
                                  input logic [LEN_W-1:0] flen,
                                  input logic [QT_W-1:0] qtime,
                                  input logic [IDX_W-1:0] idx,
                                  output t_lookup_reply r);
        int k;
        logic [QT_W-1:0] wrapped;
        logic [QT_W-1:0] first;
        r = '0;
        r.ok = 1'b1;
        case (cmd)
            CMD_CLEAR: begin
                n_entries = 0;
                run_total = '0;
                appending = 1'b1;
            end
            CMD_APPEND: begin
                if (appending && sprite_valid && n_entries < MAX_ENTRIES / 2)
                    place_entry(flen, fref, tag);
                else
                    r.ok = 1'b0;
            end
            CMD_END: begin
                // ping-pong: inner entries replayed backwards after the last one
                if (appending && play_mode == MODE_PINGPONG && n_entries >= 3) begin
                    for (k = n_entries - 2; k >= 1 && n_entries < MAX_ENTRIES; k--)
                        place_entry(timeline[k].length, timeline[k].frame_ref,
                                    timeline[k].tag);
                end
                appending = 1'b0;
            end
            CMD_QUERY: begin
                // negative, past the end when playing once, or empty timeline: miss
                if (!qtime[QT_W-1] && !(play_mode == MODE_ONCE && qtime >= run_total)
                        && run_total != '0) begin
                    wrapped = qtime % run_total;
                    for (k = 0; k < n_entries; k++) begin
                        first = QT_W'(timeline[k].start);
                        if (!r.hit && wrapped >= first
                                && wrapped < first + timeline[k].length)
                            r = entry_reply(k);
                    end
                end
            end
            CMD_READ: begin
                if (idx < n_entries)
                    r = entry_reply(32'(idx));
            end
            default: ;
        endcase
        r.total = run_total;
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup_reply want;
        if (!i_rst_n) begin
            n_entries = 0;
            run_total = '0;
            appending = 1'b0;
            play_mode = MODE_ONCE;
            replies_due.delete();
        end else begin
            // a result leaves before a new item is taken at the same edge
            if (o_strobe) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: result strobed with nothing outstanding", $time);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    compare_field("ok_flag", 32'(want.ok), 32'(o_ok_flag));
                    compare_field("hit", 32'(want.hit), 32'(o_hit));
                    compare_field("found_index", 32'(want.index), 32'(o_found_index));
                    compare_field("out_ref", 32'(want.frame_ref), 32'(o_out_ref));
                    compare_field("out_tag", 32'(want.tag), 32'(o_out_tag));
                    compare_field("out_start", 32'(want.start_time), 32'(o_out_start));
                    compare_field("out_length", 32'(want.length), 32'(o_out_length));
                    compare_field("out_total", 32'(want.total), 32'(o_out_total));
                end
            end
            if (i_cfg_we)
                play_mode = i_cfg_wdata;
            if (start && !busy) begin
                predict_lookup(i_cmd, i_sprite_valid, i_tag_code, i_frame_ref,
                               i_frame_length, i_query_time, i_entry_index, want);
                replies_due = {replies_due, want};
            end
        end
        o_fail_count   <= mismatches;
        o_results_owed <= replies_due.size();
    end

endmodule

>>> sim/animation_frame_timeline_lookup_test.sv
// Testbench top for the sprite animation timeline store: makes commands and loop mode
// writes, runs the watchdog and gives the verdict. Depends on afl_pkg, the block and
// animation_frame_timeline_lookup_checker.
module animation_frame_timeline_lookup_test;
    import afl_pkg::*;

    localparam int MAX_ENTRIES = 128;
    localparam int ITEM_TARGET = 750;
    localparam int STALL_LIMIT = 40000;

    // codes the block does not know
    localparam logic [CMD_W-1:0]  CMD_SPARE_FIRST = CMD_READ + 1'b1;
    localparam logic [CMD_W-1:0]  CMD_SPARE_LAST  = '1;
    localparam logic [MODE_W-1:0] MODE_SPARE      = '1;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic                    sprite_valid;
        logic signed [TAG_W-1:0] tag;
        logic [REF_W-1:0]        frame_ref;
        logic [LEN_W-1:0]        frame_length;
        logic signed [QT_W-1:0]  query_time;
        logic [IDX_W-1:0]        entry_index;
    } t_timeline_cmd;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_cfg_we;
    logic [MODE_W-1:0]       i_cfg_wdata;
    logic [CMD_W-1:0]        i_cmd;
    logic                    i_sprite_valid;
    logic signed [TAG_W-1:0] i_tag_code;
    logic [REF_W-1:0]        i_frame_ref;
    logic [LEN_W-1:0]        i_frame_length;
    logic signed [QT_W-1:0]  i_query_time;
    logic [IDX_W-1:0]        i_entry_index;
    logic                    o_strobe;
    logic                    o_ok_flag;
    logic                    o_hit;
    logic [IDX_W-1:0]        o_found_index;
    logic [REF_W-1:0]        o_out_ref;
    logic signed [TAG_W-1:0] o_out_tag;
    logic [TOTAL_W-1:0]      o_out_start;
    logic [LEN_W-1:0]        o_out_length;
    logic [TOTAL_W-1:0]      o_out_total;

    int                 fail_count;
    int                 results_owed;
    int                 idle_cycles = 0;
    int                 items_sent = 0;
    logic [TOTAL_W-1:0] last_total = '0;
    bit                 gaps_on = 1'b1;

    animation_frame_timeline_lookup #(.MAX_ENTRIES(MAX_ENTRIES)) DUT (.*);

    animation_frame_timeline_lookup_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_checker (
        .*,
        .o_fail_count  (fail_count),
        .o_results_owed(results_owed)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // latest total seen, used to aim query times at the timeline
    always @(posedge i_clk) begin
        if (o_strobe)
            last_total <= o_out_total;
    end

    // watchdog: too long without an item taken or a result given
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // every field random; callers override what matters
    function automatic t_timeline_cmd random_cmd(input logic [CMD_W-1:0] cmd);
        t_timeline_cmd c;
        int sel;
        c.cmd          = cmd;
        c.sprite_valid = ($urandom_range(0, 9) != 0);
        c.tag          = TAG_W'($urandom_range(0, 256) - 1);
        c.frame_ref    = REF_W'($urandom());
        c.query_time   = $urandom();
        c.entry_index  = IDX_W'($urandom());
        sel = $urandom_range(0, 19);
        if (sel < 2)
            c.frame_length = '0;
        else if (sel < 4)
            c.frame_length = LEN_W'($urandom());
        else if (sel == 4)
            c.frame_length = '1;
        else
            c.frame_length = LEN_W'($urandom_range(1, 40));
        return c;
    endfunction

    // mostly inside the timeline, some past its end, some anywhere
    function automatic logic signed [QT_W-1:0] pick_query_time();
        int unsigned span;
        int sel;
        span = (last_total == '0) ? 1 : last_total;
        sel = $urandom_range(0, 19);
        if (sel < 12)
            return $urandom_range(0, span - 1);
        else if (sel < 15)
            return $urandom_range(span, 4 * span);
        else if (sel == 15)
            return span - 1;
        else if (sel == 16)
            return span;
        else
            return $urandom();
    endfunction

    // present one item, with random idle cycles first while gaps are on, and wait until busy drops
    task automatic issue(input t_timeline_cmd c);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 34) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start          <= 1'b1;
        i_cmd          <= c.cmd;
        i_sprite_valid <= c.sprite_valid;
        i_tag_code     <= c.tag;
        i_frame_ref    <= c.frame_ref;
        i_frame_length <= c.frame_length;
        i_query_time   <= c.query_time;
        i_entry_index  <= c.entry_index;
        do @(posedge i_clk); while (busy);
        if (c.cmd <= CMD_READ)
            items_sent++;
    endtask

    task automatic send_plain(input logic [CMD_W-1:0] cmd);
        issue(random_cmd(cmd));
    endtask

    task automatic send_append(input logic sv, input logic signed [TAG_W-1:0] tag,
                               input logic [REF_W-1:0] fref, input logic [LEN_W-1:0] flen);
        t_timeline_cmd c;
        c = random_cmd(CMD_APPEND);
        c.sprite_valid = sv;
        c.tag          = tag;
        c.frame_ref    = fref;
        c.frame_length = flen;
        issue(c);
    endtask

    task automatic send_query(input logic signed [QT_W-1:0] qt);
        t_timeline_cmd c;
        c = random_cmd(CMD_QUERY);
        c.query_time = qt;
        issue(c);
    endtask

    task automatic send_read(input logic [IDX_W-1:0] idx);
        t_timeline_cmd c;
        c = random_cmd(CMD_READ);
        c.entry_index = idx;
        issue(c);
    endtask

    // hold the sender off until every result is in
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0 || busy)
            @(posedge i_clk);
    endtask

    task automatic set_play_mode(input logic [MODE_W-1:0] mode);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int j;
        int n_frames;
        int n_lookups;
        int seq;
        int phase;
        seq   = 0;
        phase = 0;

        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        i_cmd          <= CMD_CLEAR;
        i_sprite_valid <= 1'b0;
        i_tag_code     <= '0;
        i_frame_ref    <= '0;
        i_frame_length <= '0;
        i_query_time   <= '0;
        i_entry_index  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty and closed after reset
        send_query(0);
        send_read(0);
        send_append(1'b1, 5, 7, 3);
        send_plain(CMD_SPARE_FIRST);

        // field extremes while playing once; total becomes 65536
        send_plain(CMD_CLEAR);
        send_append(1'b0, 1, 1, 1);
        send_append(1'b1, -1, '1, '1);
        send_append(1'b1, 255, '0, '0);
        send_append(1'b1, 0, 16'h5a5a, 1);
        send_plain(CMD_END);
        send_plain(CMD_END);
        send_append(1'b1, 3, 3, 3);
        send_query(65535);
        send_query(65536);
        send_query(-1);
        send_query(32'h7fff_ffff);
        send_read(2);
        send_read('1);

        // ping-pong mirror of the smallest timeline that has one
        set_play_mode(MODE_PINGPONG);
        send_plain(CMD_CLEAR);
        send_append(1'b1, 10, 100, 4);
        send_append(1'b1, 11, 101, 5);
        send_append(1'b1, 12, 102, 6);
        send_plain(CMD_END);
        send_query(32'h7fff_ffff);
        send_read(3);

        // random sequences: clear, appends, end, then lookups
        while (items_sent < ITEM_TARGET) begin
            // new loop mode every six sequences; one phase runs with no sender gaps
            if (seq % 6 == 0) begin
                set_play_mode(phase < 4 ? MODE_W'(phase)
                                        : MODE_W'($urandom_range(MODE_ONCE, MODE_SPARE)));
                gaps_on = (phase != 2);
                phase++;
            end
            seq++;

            if ($urandom_range(0, 19) == 0)
                issue(random_cmd(CMD_W'($urandom())));

            // a few long timelines reach the append limit and the longest mirror
            n_frames = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 68)
                                                    : $urandom_range(1, 8);
            send_plain(CMD_CLEAR);
            for (j = 0; j < n_frames; j++)
                issue(random_cmd(CMD_APPEND));
            if ($urandom_range(0, 9) != 0)
                send_plain(CMD_END);
            if ($urandom_range(0, 4) == 0)
                issue(random_cmd(CMD_APPEND));

            // mostly wait for the final total so query times land on the timeline
            if ($urandom_range(0, 3) != 0)
                drain_results();

            n_lookups = $urandom_range(4, 14);
            for (j = 0; j < n_lookups; j++) begin
                case ($urandom_range(0, 11))
                    0, 1, 2: send_read(($urandom_range(0, 3) == 0)
                                       ? IDX_W'($urandom())
                                       : IDX_W'($urandom_range(0, 2 * n_frames)));
                    3:       issue(random_cmd(CMD_W'($urandom())));
                    default: send_query(pick_query_time());
                endcase
            end
        end

        drain_results();
        repeat (MAX_ENTRIES + 40) @(posedge i_clk);
        if (fail_count == 0 && results_owed == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
